/* src/tcw_pkg.sv */
// Shared types and constants of the text console writer.
package tcw_pkg;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int LIN_W  = 11;
  localparam int CHAR_W = 8;
  localparam int CELL_W = 16;

  // Command codes.
  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_SET   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  // Configuration register indexes.
  localparam logic REG_DISP = 1'b0;
  localparam logic REG_ATTR = 1'b1;

  localparam logic [7:0] CH_NL        = 8'd10;
  localparam logic [7:0] CH_CR        = 8'd13;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] ATTR_DEFAULT = 8'h07;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } cur_pos_t;

  // Cursor update request for one accepted item.
  typedef struct packed {
    logic              upd;
    logic              is_put;
    logic [1:0]        term;
    logic [CHAR_W-1:0] ch;
    logic [7:0]        pos_col;
    logic [5:0]        pos_row;
  } cur_req_t;

  // What a put does to the cell store.
  typedef struct packed {
    cur_pos_t old;
    logic     wr_char;
    logic     scroll;
  } cur_plan_t;

endpackage

/* src/text_console_writer.sv */
// Top level of the text console writer: sequencer, configuration and result register.
//
//  port group | direction | handshake        | contents
//  in_*       | input     | in_valid/in_stall | cmd, term, ch, pos_col, pos_row
//  out_*      | output    | out_valid/out_stall | cursor, linear position, shown, cell
//  cfg_*      | input     | cfg_we           | index 0 displayed terminal, 1 attribute
//
// Set cursor, read cell, a put without scroll and any command to a missing
// terminal go from the accept cycle to the finish state, which loads the result.
// Clear and a scrolling put walk the terminal's cells through the single write
// port of the cell store, one cell a cycle, before the result is loaded.
// After reset the cell store is blanked one entry a cycle over its whole
// power-of-two address space (16384 entries at the default size) and no item is
// accepted until that is done; configuration writes are taken throughout.
// A finished result waits in the output register while out_stall is high.
module text_console_writer #(
  parameter int ROWS  = 25,
  parameter int COLS  = 80,
  parameter int TERMS = 3
) (
  input  logic       clk,
  input  logic       rst_n,

  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_cmd,
  input  logic [1:0] in_term,
  input  logic [7:0] in_ch,
  input  logic [7:0] in_pos_col,
  input  logic [5:0] in_pos_row,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_cursor_col,
  output logic [4:0]  out_cursor_row,
  output logic [10:0] out_cursor_linear,
  output logic        out_cursor_shown,
  output logic [7:0]  out_cell_char,
  output logic [7:0]  out_cell_attr,

  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata
);

  // Cell address is {terminal, row, column}, each field padded to a power of two.
  localparam int TAW = (TERMS > 1) ? $clog2(TERMS) : 1;
  localparam int RAW = $clog2(ROWS);
  localparam int CAW = $clog2(COLS);
  localparam int AW  = TAW + RAW + CAW;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_SWEEP,
    ST_FIN
  } state_t;

  state_t         state_r;
  logic [AW-1:0]  init_cnt_r;
  logic [1:0]     t_r;
  logic           zero_r;
  logic           shown_r;
  logic           cell_r;
  logic           sw_scroll_r;
  logic [RAW-1:0] sw_row_r;
  logic [CAW-1:0] sw_col_r;
  logic           pend_valid_r;
  logic           pend_copy_r;
  logic [AW-1:0]  pend_addr_r;
  logic [1:0]     disp_r;
  logic [7:0]     attr_r;

  logic        out_valid_r;
  logic [6:0]  out_col_r;
  logic [4:0]  out_row_r;
  logic [10:0] out_lin_r;
  logic        out_shown_r;
  logic [7:0]  out_char_r;
  logic [7:0]  out_attr_r;

  logic                   acc;
  logic                   term_ok;
  logic                   cell_ok;
  logic                   slot_free;
  logic                   last_col;
  logic                   last_row;
  logic                   copy;
  logic [12:0]            lin_full;
  tcw_pkg::cur_req_t      cur_req;
  tcw_pkg::cur_plan_t     plan;
  tcw_pkg::cur_pos_t      rd_pos;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [tcw_pkg::CELL_W-1:0]  ram_wdata;
  logic                        ram_re;
  logic [AW-1:0]               ram_raddr;
  logic [tcw_pkg::CELL_W-1:0]  ram_rdata;

  tcw_cursor #(
    .ROWS  (ROWS),
    .COLS  (COLS),
    .TERMS (TERMS)
  ) u_cursor (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (cur_req),
    .rd_term (t_r),
    .plan    (plan),
    .rd_pos  (rd_pos)
  );

  tcw_cell_ram #(
    .AW (AW),
    .DW (tcw_pkg::CELL_W)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // One item is in flight at a time; the next one waits for the result to load.
  assign in_stall  = (state_r != ST_IDLE);
  assign acc       = (state_r == ST_IDLE) && in_valid;
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    term_ok = ({1'b0, in_term} < 3'(TERMS));
    cell_ok = !in_pos_col[7] && ({1'b0, in_pos_col[6:0]} < 8'(COLS)) &&
              !in_pos_row[5] && ({1'b0, in_pos_row[4:0]} < 6'(ROWS));

    cur_req.upd     = acc && term_ok &&
                      ((in_cmd == tcw_pkg::CMD_PUT) || (in_cmd == tcw_pkg::CMD_SET));
    cur_req.is_put  = (in_cmd == tcw_pkg::CMD_PUT);
    cur_req.term    = in_term;
    cur_req.ch      = in_ch;
    cur_req.pos_col = in_pos_col;
    cur_req.pos_row = in_pos_row;

    last_col = (sw_col_r == CAW'(COLS - 1));
    last_row = (sw_row_r == RAW'(ROWS - 1));
    // During a scroll every row but the bottom one takes the row below it.
    copy     = sw_scroll_r && !last_row;

    if (state_r == ST_SWEEP) begin
      ram_re    = copy;
      ram_raddr = {t_r[TAW-1:0], sw_row_r + RAW'(1), sw_col_r};
    end else begin
      ram_re    = acc && term_ok && (in_cmd == tcw_pkg::CMD_READ) && cell_ok;
      ram_raddr = {in_term[TAW-1:0], in_pos_row[RAW-1:0], in_pos_col[CAW-1:0]};
    end

    // Each sweep write comes in the cycle after its read; the write port never sees
    // two sources at once because sweeps and reset clearing exclude new items.
    ram_we    = 1'b0;
    ram_waddr = pend_addr_r;
    ram_wdata = {attr_r, tcw_pkg::CH_SPACE};
    priority if (pend_valid_r) begin
      ram_we    = 1'b1;
      ram_waddr = pend_addr_r;
      ram_wdata = pend_copy_r ? ram_rdata : {attr_r, tcw_pkg::CH_SPACE};
    end else if (state_r == ST_INIT) begin
      ram_we    = 1'b1;
      ram_waddr = init_cnt_r;
      ram_wdata = {tcw_pkg::ATTR_DEFAULT, tcw_pkg::CH_SPACE};
    end else if (cur_req.upd && cur_req.is_put && plan.wr_char) begin
      ram_we    = 1'b1;
      ram_waddr = {in_term[TAW-1:0], plan.old.row[RAW-1:0], plan.old.col[CAW-1:0]};
      ram_wdata = {attr_r, in_ch};
    end else begin
      ram_we    = 1'b0;
    end

    lin_full = 13'(rd_pos.row) * 13'(COLS) + 13'(rd_pos.col);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      init_cnt_r   <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      disp_r       <= 2'd0;
      attr_r       <= tcw_pkg::ATTR_DEFAULT;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          tcw_pkg::REG_DISP: disp_r <= cfg_wdata[1:0];
          tcw_pkg::REG_ATTR: attr_r <= cfg_wdata;
        endcase
      end

      pend_valid_r <= (state_r == ST_SWEEP);
      pend_copy_r  <= copy;
      pend_addr_r  <= {t_r[TAW-1:0], sw_row_r, sw_col_r};

      // While a result loads, the loading branch below sets the valid flag.
      if (out_valid_r && !out_stall && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_INIT: begin
          init_cnt_r <= init_cnt_r + AW'(1);
          if (&init_cnt_r) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (acc) begin
            t_r         <= in_term;
            zero_r      <= !term_ok;
            shown_r     <= term_ok && (in_cmd == tcw_pkg::CMD_PUT) && (in_term == disp_r);
            cell_r      <= term_ok && (in_cmd == tcw_pkg::CMD_READ) && cell_ok;
            sw_scroll_r <= (in_cmd == tcw_pkg::CMD_PUT);
            sw_row_r    <= '0;
            sw_col_r    <= '0;
            if (term_ok && (((in_cmd == tcw_pkg::CMD_PUT) && plan.scroll) ||
                            (in_cmd == tcw_pkg::CMD_CLEAR))) begin
              state_r <= ST_SWEEP;
            end else begin
              state_r <= ST_FIN;
            end
          end
        end
        ST_SWEEP: begin
          if (last_col) begin
            sw_col_r <= '0;
            if (last_row) begin
              state_r <= ST_FIN;
            end else begin
              sw_row_r <= sw_row_r + RAW'(1);
            end
          end else begin
            sw_col_r <= sw_col_r + CAW'(1);
          end
        end
        ST_FIN: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_col_r   <= zero_r ? '0 : rd_pos.col;
            out_row_r   <= zero_r ? '0 : rd_pos.row;
            out_lin_r   <= zero_r ? '0 : lin_full[10:0];
            out_shown_r <= shown_r;
            out_char_r  <= cell_r ? ram_rdata[7:0] : 8'd0;
            out_attr_r  <= cell_r ? ram_rdata[15:8] : 8'd0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cursor_col    = out_col_r;
  assign out_cursor_row    = out_row_r;
  assign out_cursor_linear = out_lin_r;
  assign out_cursor_shown  = out_shown_r;
  assign out_cell_char     = out_char_r;
  assign out_cell_attr     = out_attr_r;

  // A trailing sweep write has always drained before a new item is taken.
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_valid_r)
    else $error("sweep write pending while idle");

  // The cell store never reads and writes the same entry in one cycle.
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("read and write to the same cell");

  // Pending writes only come from a sweep, ending in the cycle after it.
  a_pending_source: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> (state_r == ST_SWEEP) || (state_r == ST_FIN))
    else $error("pending write outside a sweep");

endmodule

/* src/tcw_cell_ram.sv */
// Cell store: one write port and one read port with registered read data.
module tcw_cell_ram #(
  parameter int AW = 14,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/tcw_cursor.sv */
// Per-terminal cursor registers and the cursor arithmetic for put and set.
module tcw_cursor #(
  parameter int ROWS  = 25,
  parameter int COLS  = 80,
  parameter int TERMS = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tcw_pkg::cur_req_t    req,
  input  logic [1:0]           rd_term,
  output tcw_pkg::cur_plan_t   plan,
  output tcw_pkg::cur_pos_t    rd_pos
);

  localparam int TAW   = (TERMS > 1) ? $clog2(TERMS) : 1;
  localparam int SLOTS = 2**TAW;

  tcw_pkg::cur_pos_t pos_r [SLOTS];

  tcw_pkg::cur_pos_t old_pos;
  tcw_pkg::cur_pos_t put_pos;
  tcw_pkg::cur_pos_t set_pos;
  tcw_pkg::cur_pos_t new_pos;
  logic              nl;
  logic              scroll;
  logic [7:0]        col_inc;
  logic [5:0]        row_inc;
  logic [5:0]        row_next;
  logic [8:0]        sc;
  logic [6:0]        sr;
  logic              set_ok;

  always_comb begin
    old_pos  = pos_r[req.term[TAW-1:0]];
    nl       = (req.ch == tcw_pkg::CH_NL) || (req.ch == tcw_pkg::CH_CR);
    col_inc  = {1'b0, old_pos.col} + 8'd1;
    row_inc  = {1'b0, old_pos.row} + 6'd1;
    put_pos  = old_pos;
    scroll   = 1'b0;
    priority if (nl) begin
      put_pos.col = '0;
      row_next    = row_inc;
    end else if (col_inc >= 8'(COLS)) begin
      put_pos.col = '0;
      row_next    = row_inc;
    end else begin
      put_pos.col = col_inc[6:0];
      row_next    = {1'b0, old_pos.row};
    end
    if (row_next >= 6'(ROWS)) begin
      scroll      = 1'b1;
      put_pos.row = 5'(ROWS - 1);
      put_pos.col = '0;
    end else begin
      put_pos.row = row_next[4:0];
    end

    // A negative column means the last column of the row above.
    sc = {req.pos_col[7], req.pos_col};
    sr = {req.pos_row[5], req.pos_row};
    if (sc[8]) begin
      sr = sr - 7'd1;
      sc = 9'(COLS - 1);
    end
    set_ok  = !sc[8] && (sc[7:0] < 8'(COLS)) && !sr[6] && (sr[5:0] < 6'(ROWS));
    set_pos = set_ok ? tcw_pkg::cur_pos_t'{col: sc[6:0], row: sr[4:0]} : old_pos;
    new_pos = req.is_put ? put_pos : set_pos;

    plan.old     = old_pos;
    plan.wr_char = !nl;
    plan.scroll  = scroll;
    rd_pos       = pos_r[rd_term[TAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        pos_r[i] <= '0;
      end
    end else if (req.upd) begin
      pos_r[req.term[TAW-1:0]] <= new_pos;
    end
  end

  // A cursor that gets updated was always on the screen.
  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    req.upd |-> (old_pos.row <= 5'(ROWS - 1)) && ({1'b0, old_pos.col} < 8'(COLS)))
    else $error("cursor left the screen");

endmodule
